FILE: rtl/sk384_pkg.sv
// ----------------------------------------------------------------------------
// sk384_pkg
// Shared types, constants and GF(2^8) helpers for the masked Skinny core.
// ----------------------------------------------------------------------------
package sk384_pkg;

	localparam logic [1:0] CMD_LOAD_BLOCK = 2'd0;
	localparam logic [1:0] CMD_LOAD_TK    = 2'd1;
	localparam logic [1:0] CMD_ENCRYPT    = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TABLE,
		ST_MASK,
		ST_SUB,
		ST_ROUND,
		ST_UNMASK,
		ST_OUT0,
		ST_OUT1
	} state_t;

	typedef struct packed {
		logic       tab_we;
		logic       sub_rd;
	} ctrl_t;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] x;
		logic [7:0] p;
		x = a;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	function automatic logic [7:0] sbox8(input logic [7:0] x);
		logic [7:0] v;
		v = x;
		for (int j = 0; j < 4; j++) begin
			v = {v[7:5], v[4] ^ ~(v[7] | v[6]), v[3:1], v[0] ^ ~(v[3] | v[2])};
			if (j < 3) v = {v[2], v[1], v[7], v[6], v[4], v[0], v[3], v[5]};
			else v = {v[7:3], v[1], v[2], v[0]};
		end
		return v;
	endfunction

	function automatic logic [7:0] lfsr_l(input logic [7:0] k);
		return {k[6:0], k[7] ^ k[5]};
	endfunction

	function automatic logic [7:0] lfsr_r(input logic [7:0] k);
		return {k[0] ^ k[6], k[7:1]};
	endfunction

	localparam logic [3:0] TK_PERM [16] = '{4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12,
		4'd11, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7};

endpackage

FILE: rtl/masked_skinny128_384_encrypt_core.sv
// ----------------------------------------------------------------------------
// masked_skinny128_384_encrypt_core
// Skinny-128-384+ encryption on affine-masked bytes, iterative byte datapath.
// ----------------------------------------------------------------------------
//  channel   | handshake         | payload
//  in        | in_valid/in_stall | command word_index data_word mult_mask add_mask
//  out       | out_valid/out_stall | result_word result_index last
//  cfg       | cfg_valid/cfg_ready | cfg_data (round_count)
// Loads are registered while idle. Encrypt: table build (mask inverse built alongside),
// masking, then per round 16 S-box and 16 LFSR lookups through the shared
// table read address, the last read data and one round step, then unmasking
// and two output transfers. Reset clears control only.
// Output holds while stalled; no input is taken until both words leave.
module masked_skinny128_384_encrypt_core #(
	parameter int TK_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [2:0]  word_index,
	input  logic [63:0] data_word,
	input  logic [7:0]  mult_mask,
	input  logic [7:0]  add_mask,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_word,
	output logic        result_index,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);
	import sk384_pkg::*;

	state_t state_q, state_n;
	ctrl_t  ctrl;
	logic [5:0] rcount_q, round_q, rc_q;
	logic [7:0] mmul_q, madd_q, inv_q;
	logic [8:0] cnt_q;
	logic [7:0] blk_q [16];
	logic [63:0] tkr_q [6];
	logic [7:0] st_q [16];
	logic [7:0] tk_q [3][16];
	logic [7:0] rd_addr, rd_sbox, rd_left, rd_right, k8, mk, src;
	logic [7:0] unmask_byte;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign k8 = cnt_q[7:0];
	assign mk = gf_mul(mmul_q, k8) ^ madd_q;

	function automatic logic [7:0] mof(input logic [7:0] m, input logic [7:0] a,
		input logic [7:0] x);
		return gf_mul(m, x) ^ a;
	endfunction

	// lookups: cnt 0..15 S-box on state bytes, 16..23 left LFSR, 24..31 right
	// LFSR, both on tk bytes 8..15 (they land in 0..7 after the permutation)
	always_comb begin
		src = st_q[cnt_q[3:0]];
		if (cnt_q[4])
			src = cnt_q[3] ? tk_q[2][{1'b1, cnt_q[2:0]}] : tk_q[1][{1'b1, cnt_q[2:0]}];
		rd_addr = src;
	end

	always_comb begin
		ctrl.tab_we = (state_q == ST_TABLE);
		ctrl.sub_rd = (state_q == ST_SUB) && (cnt_q < 9'd32);
	end

	sk384_tables u_tab (
		.clk(clk), .ctrl(ctrl), .wr_addr(mk),
		.wr_sbox(mof(mmul_q, madd_q, sbox8(k8))),
		.wr_left(mof(mmul_q, madd_q, lfsr_l(k8))),
		.wr_right(mof(mmul_q, madd_q, lfsr_r(k8))),
		.rd_addr(rd_addr), .rd_sbox(rd_sbox), .rd_left(rd_left), .rd_right(rd_right)
	);

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid && command == CMD_ENCRYPT) state_n = ST_TABLE;
			ST_TABLE:  if (cnt_q == 9'd255) state_n = ST_MASK;
			ST_MASK:   if (cnt_q == 9'd15) state_n = (rcount_q == 6'd0) ? ST_UNMASK : ST_SUB;
			ST_SUB:    if (cnt_q == 9'd32) state_n = ST_ROUND;
			ST_ROUND:  state_n = (round_q + 6'd1 == rcount_q) ? ST_UNMASK : ST_SUB;
			ST_UNMASK: if (cnt_q == 9'd15) state_n = ST_OUT0;
			ST_OUT0:   if (!out_stall) state_n = ST_OUT1;
			ST_OUT1:   if (!out_stall) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		out_valid    = (state_q == ST_OUT0) || (state_q == ST_OUT1);
		result_index = (state_q == ST_OUT1);
		last         = (state_q == ST_OUT1);
		for (int k = 0; k < 8; k++)
			result_word[8*k +: 8] = (state_q == ST_OUT1) ? st_q[8 + k] : st_q[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rcount_q  <= 6'd40;
			cnt_q     <= '0;
			round_q   <= '0;
			rc_q      <= '0;
			mmul_q    <= 8'd1;
			madd_q    <= 8'd0;
		end else begin
			state_q <= state_n;
			if (cfg_valid) rcount_q <= cfg_data;
			if (state_q != state_n) cnt_q <= '0;
			else cnt_q <= cnt_q + 9'd1;
			case (state_q)
				ST_IDLE: if (in_valid && command == CMD_ENCRYPT) begin
					mmul_q  <= (mult_mask == 8'd0) ? 8'd1 : mult_mask;
					madd_q  <= add_mask;
					round_q <= '0;
					rc_q    <= '0;
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					rc_q    <= {rc_q[4:0], rc_q[5] ^ rc_q[4] ^ 1'b1};
				end
				default: ;
			endcase
		end
	end

	// payload path
	logic [5:0] rc_n;
	logic [7:0] ar [16];
	logic [7:0] sr [16];
	assign rc_n = {rc_q[4:0], rc_q[5] ^ rc_q[4] ^ 1'b1};
	assign unmask_byte = gf_mul(st_q[cnt_q[3:0]] ^ madd_q, inv_q);
	always_comb begin
		for (int i = 0; i < 16; i++) ar[i] = st_q[i];
		ar[0] = ar[0] ^ madd_q ^ mof(mmul_q, madd_q, {4'd0, rc_n[3:0]});
		ar[4] = ar[4] ^ madd_q ^ mof(mmul_q, madd_q, {6'd0, rc_n[5:4]});
		ar[8] = ar[8] ^ madd_q ^ mof(mmul_q, madd_q, 8'd2);
		for (int i = 0; i < 8; i++)
			for (int t = 0; t < 3; t++)
				if (t < TK_COUNT) ar[i] = ar[i] ^ tk_q[t][i] ^ madd_q;
		for (int i = 0; i < 4; i++)
			for (int c = 0; c < 4; c++)
				sr[4*i + c] = ar[4*i + ((c + 4 - i) & 3)];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			if (command == CMD_LOAD_BLOCK && word_index < 3'd2)
				for (int k = 0; k < 8; k++) blk_q[{word_index[0], 3'(k)}] <= data_word[8*k +: 8];
			if (command == CMD_LOAD_TK && word_index < 3'd6)
				tkr_q[word_index] <= data_word;
		end
		// mask inverse as r1^254, one multiply per table cycle while cnt is below 254
		if (state_q == ST_IDLE) inv_q <= 8'd1;
		if (state_q == ST_TABLE && cnt_q < 9'd254) inv_q <= gf_mul(inv_q, mmul_q);
		if (state_q == ST_MASK) begin
			st_q[cnt_q[3:0]] <= mof(mmul_q, madd_q, blk_q[cnt_q[3:0]]);
			for (int t = 0; t < 3; t++)
				tk_q[t][cnt_q[3:0]] <= mof(mmul_q, madd_q,
					tkr_q[3'(2*t) + {2'd0, cnt_q[3]}][{cnt_q[2:0], 3'd0} +: 8]);
		end
		if (state_q == ST_SUB && cnt_q != 9'd0) begin
			if (cnt_q <= 9'd16) st_q[4'(cnt_q - 9'd1)] <= rd_sbox;
			else if (cnt_q <= 9'd24) tk_q[1][{1'b1, 3'(cnt_q - 9'd17)}] <= rd_left;
			else tk_q[2][{1'b1, 3'(cnt_q - 9'd25)}] <= rd_right;
		end
		if (state_q == ST_ROUND) begin
			for (int c = 0; c < 4; c++) begin
				st_q[c]      <= sr[12+c] ^ sr[8+c] ^ sr[c] ^ madd_q ^ madd_q;
				st_q[4 + c]  <= sr[c];
				st_q[8 + c]  <= sr[4+c] ^ sr[8+c] ^ madd_q;
				st_q[12 + c] <= sr[8+c] ^ sr[c] ^ madd_q;
			end
			for (int t = 0; t < 3; t++)
				for (int i = 0; i < 16; i++) tk_q[t][i] <= tk_q[t][TK_PERM[i]];
		end
		// ciphertext also becomes the stored block
		if (state_q == ST_UNMASK) begin
			st_q[cnt_q[3:0]]  <= unmask_byte;
			blk_q[cnt_q[3:0]] <= unmask_byte;
		end
	end
endmodule

FILE: rtl/sk384_tables.sv
// ----------------------------------------------------------------------------
// sk384_tables
// Masked S-box and tweakey LFSR tables, one shared write port, one read each.
// ----------------------------------------------------------------------------
module sk384_tables (
	input  logic                 clk,
	input  sk384_pkg::ctrl_t     ctrl,
	input  logic [7:0]           wr_addr,
	input  logic [7:0]           wr_sbox,
	input  logic [7:0]           wr_left,
	input  logic [7:0]           wr_right,
	input  logic [7:0]           rd_addr,
	output logic [7:0]           rd_sbox,
	output logic [7:0]           rd_left,
	output logic [7:0]           rd_right
);
	import sk384_pkg::*;

	logic [7:0] sbox_mem [256];
	logic [7:0] left_mem [256];
	logic [7:0] right_mem [256];

	always_ff @(posedge clk) begin
		if (ctrl.tab_we) begin
			sbox_mem[wr_addr]  <= wr_sbox;
			left_mem[wr_addr]  <= wr_left;
			right_mem[wr_addr] <= wr_right;
		end
		if (ctrl.sub_rd) begin
			rd_sbox  <= sbox_mem[rd_addr];
			rd_left  <= left_mem[rd_addr];
			rd_right <= right_mem[rd_addr];
		end
	end
endmodule
